FILE: hw/rtl/acir_pkg.sv
`timescale 1ns / 1ps
package acir_pkg;

  localparam int SYM_INDEX_W    = 9;
  localparam int BYTE_INDEX_W   = 5;
  localparam int DUR_W          = 16;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 16;

  localparam int PREAMBLE_SYMS  = 12;
  localparam int HDR_MARK_SYM   = 12;
  localparam int HDR_SPACE_SYM  = 13;
  localparam int DATA_START     = 14;
  localparam int FINAL_SYM      = 318;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Fixed template bytes.
  localparam logic [7:0] BYTE_0  = 8'h11;
  localparam logic [7:0] BYTE_1  = 8'hDA;
  localparam logic [7:0] BYTE_2  = 8'h27;
  localparam logic [7:0] BYTE_15 = 8'hC5;
  localparam logic [7:0] TEMPLATE_SUM = 8'(BYTE_0 + BYTE_1 + BYTE_2 + BYTE_15);

  // Register reset values.
  localparam logic [DUR_W-1:0] MARK_US_RST         = 16'd479;
  localparam logic [DUR_W-1:0] ZERO_SPACE_US_RST   = 16'd389;
  localparam logic [DUR_W-1:0] ONE_SPACE_US_RST    = 16'd1260;
  localparam logic [DUR_W-1:0] LEAD_GAP_US_RST     = 16'd25175;
  localparam logic [DUR_W-1:0] HEADER_MARK_US_RST  = 16'd3524;
  localparam logic [DUR_W-1:0] HEADER_SPACE_US_RST = 16'd1692;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_MARK_US         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_SPACE_US   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ONE_SPACE_US    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEAD_GAP_US     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_MARK_US  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SPACE_US = 3'd5;

  typedef enum logic [2:0] {
    SYM_MARK,
    SYM_ZERO_SPACE,
    SYM_ONE_SPACE,
    SYM_LEAD_GAP,
    SYM_HDR_MARK,
    SYM_HDR_SPACE,
    SYM_FINAL
  } sym_kind_t;

  typedef struct packed {
    logic      valid;
    sym_kind_t kind;
  } sym_xfer_t;

  function automatic logic [7:0] frame_byte(
    input logic [BYTE_INDEX_W-1:0] n,
    input logic [7:0] mode_power,
    input logic [7:0] temp,
    input logic [7:0] fan_swing,
    input logic [7:0] eco,
    input logic [7:0] sum
  );
    logic [7:0] b;
    unique case (n)
      5'd0:    b = BYTE_0;
      5'd1:    b = BYTE_1;
      5'd2:    b = BYTE_2;
      5'd5:    b = mode_power;
      5'd6:    b = temp;
      5'd8:    b = fan_swing;
      5'd15:   b = BYTE_15;
      5'd16:   b = eco;
      5'd18:   b = sum;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/acir_front.sv
`timescale 1ns / 1ps
module acir_front import acir_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       action,
  input  logic [7:0] temp_code,
  input  logic [3:0] mode,
  input  logic       power_off,
  input  logic [3:0] fan,
  input  logic [3:0] swing,
  input  logic [7:0] eco,
  output sym_xfer_t  push
);

  logic [7:0] temp_byte;
  logic [7:0] mode_power_byte;
  logic [7:0] fan_swing_byte;
  logic [7:0] eco_byte;
  logic [7:0] sum_byte;
  logic [SYM_INDEX_W-1:0] symbol_index;
  logic frame_pending;

  logic [7:0] mp_new;
  logic [7:0] fs_new;
  logic [SYM_INDEX_W-1:0] data_offs;
  logic [7:0] bit_num;
  logic [7:0] cur_byte;
  logic       bit_val;
  sym_kind_t  kind;

  assign mp_new = {mode, 3'b000, power_off};
  assign fs_new = {fan, swing};

  // Locate the frame bit carried by the current space.
  assign data_offs = symbol_index - SYM_INDEX_W'(DATA_START);
  assign bit_num   = data_offs[SYM_INDEX_W-1:1];
  assign cur_byte  = frame_byte(bit_num[7:3], mode_power_byte, temp_byte,
                                fan_swing_byte, eco_byte, sum_byte);
  assign bit_val   = cur_byte[bit_num[2:0]];

  always_comb begin
    if (symbol_index < SYM_INDEX_W'(PREAMBLE_SYMS)) begin
      if (!symbol_index[0]) begin
        kind = SYM_MARK;
      end else if (symbol_index == SYM_INDEX_W'(PREAMBLE_SYMS - 1)) begin
        kind = SYM_LEAD_GAP;
      end else begin
        kind = SYM_ZERO_SPACE;
      end
    end else if (symbol_index == SYM_INDEX_W'(HDR_MARK_SYM)) begin
      kind = SYM_HDR_MARK;
    end else if (symbol_index == SYM_INDEX_W'(HDR_SPACE_SYM)) begin
      kind = SYM_HDR_SPACE;
    end else if (symbol_index < SYM_INDEX_W'(FINAL_SYM)) begin
      if (!data_offs[0]) begin
        kind = SYM_MARK;
      end else if (bit_val) begin
        kind = SYM_ONE_SPACE;
      end else begin
        kind = SYM_ZERO_SPACE;
      end
    end else begin
      kind = SYM_FINAL;
    end
  end

  assign push.valid = accept && action && frame_pending;
  assign push.kind  = kind;

  always_ff @(posedge clk) begin
    if (accept && !action) begin
      temp_byte       <= temp_code;
      mode_power_byte <= mp_new;
      fan_swing_byte  <= fs_new;
      eco_byte        <= eco;
      sum_byte        <= TEMPLATE_SUM + temp_code + mp_new + fs_new + eco;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_index  <= '0;
      frame_pending <= 1'b0;
    end else if (accept && !action) begin
      symbol_index  <= '0;
      frame_pending <= 1'b1;
    end else if (push.valid) begin
      if (kind == SYM_FINAL) begin
        symbol_index  <= '0;
        frame_pending <= 1'b0;
      end else begin
        symbol_index <= symbol_index + 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/acir_queue.sv
`timescale 1ns / 1ps
module acir_queue import acir_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  sym_xfer_t push,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output sym_kind_t head_kind
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sym_kind_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_kind  = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/acir_back.sv
`timescale 1ns / 1ps
module acir_back import acir_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   head_valid,
  input  sym_kind_t              head_kind,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   is_mark,
  output logic [DUR_W-1:0]       duration_us,
  output logic                   last_symbol
);

  logic [DUR_W-1:0] mark_us;
  logic [DUR_W-1:0] zero_space_us;
  logic [DUR_W-1:0] one_space_us;
  logic [DUR_W-1:0] lead_gap_us;
  logic [DUR_W-1:0] header_mark_us;
  logic [DUR_W-1:0] header_space_us;

  logic             sel_mark;
  logic [DUR_W-1:0] sel_dur;
  logic             sel_last;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_us         <= MARK_US_RST;
      zero_space_us   <= ZERO_SPACE_US_RST;
      one_space_us    <= ONE_SPACE_US_RST;
      lead_gap_us     <= LEAD_GAP_US_RST;
      header_mark_us  <= HEADER_MARK_US_RST;
      header_space_us <= HEADER_SPACE_US_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MARK_US:         mark_us         <= cfg_data;
        CFG_ZERO_SPACE_US:   zero_space_us   <= cfg_data;
        CFG_ONE_SPACE_US:    one_space_us    <= cfg_data;
        CFG_LEAD_GAP_US:     lead_gap_us     <= cfg_data;
        CFG_HEADER_MARK_US:  header_mark_us  <= cfg_data;
        CFG_HEADER_SPACE_US: header_space_us <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sel_mark = 1'b1;
    sel_dur  = mark_us;
    sel_last = 1'b0;
    unique case (head_kind)
      SYM_MARK: begin
        sel_mark = 1'b1;
        sel_dur  = mark_us;
      end
      SYM_ZERO_SPACE: begin
        sel_mark = 1'b0;
        sel_dur  = zero_space_us;
      end
      SYM_ONE_SPACE: begin
        sel_mark = 1'b0;
        sel_dur  = one_space_us;
      end
      SYM_LEAD_GAP: begin
        sel_mark = 1'b0;
        sel_dur  = lead_gap_us;
      end
      SYM_HDR_MARK: begin
        sel_mark = 1'b1;
        sel_dur  = header_mark_us;
      end
      SYM_HDR_SPACE: begin
        sel_mark = 1'b0;
        sel_dur  = header_space_us;
      end
      SYM_FINAL: begin
        sel_mark = 1'b1;
        sel_dur  = mark_us;
        sel_last = 1'b1;
      end
      default: ;
    endcase
  end

  // Refill the output register from the queue head whenever it is empty or being drained.
  assign pop = head_valid && (!out_valid || !out_stall);

  always_comb begin
    if (pop) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_mark     <= sel_mark;
      duration_us <= sel_dur;
      last_symbol <= sel_last;
    end
  end

endmodule

FILE: hw/rtl/ac_ir_frame_encoder_top.sv
`timescale 1ns / 1ps
// Path: an accepted fetch's symbol is written into the symbol queue, then into the output register.
// Throughput: one item per cycle, loads and fetches alike, while the queue has room; the output
//   register and the symbol queue let intake continue while a finished symbol waits to be taken.
// Reset (rst, synchronous): drop any pending frame, empty the queue and output register,
//   and return all timing registers to their default durations.
module ac_ir_frame_encoder_top import acir_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Command channel: loads build a frame, fetches pull one symbol each while a frame is pending.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   action,
  input  logic [7:0]             temp_code,
  input  logic [3:0]             mode,
  input  logic                   power_off,
  input  logic [3:0]             fan,
  input  logic [3:0]             swing,
  input  logic [7:0]             eco,
  // Symbol channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   is_mark,
  output logic [DUR_W-1:0]       duration_us,
  output logic                   last_symbol,
  // Timing register write port.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  sym_xfer_t push;
  logic      q_full;
  logic      q_head_valid;
  sym_kind_t q_head_kind;
  logic      q_pop;
  logic      in_accept;

  // Hold the command channel only while the queue has no room.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // Register writes are always taken; the user must send them only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  // Front end: owns the frame bytes and the symbol counter, and resolves each
  // fetch into a symbol kind with the frame bit already looked up, so a later
  // load cannot disturb symbols still waiting in the queue.
  acir_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .action    (action),
    .temp_code (temp_code),
    .mode      (mode),
    .power_off (power_off),
    .fan       (fan),
    .swing     (swing),
    .eco       (eco),
    .push      (push)
  );

  // Short queue of symbol kinds between the two halves.
  acir_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_kind  (q_head_kind)
  );

  // Back end: maps a kind to its mark flag and duration from the timing
  // registers and presents it through the output register.
  acir_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .head_valid  (q_head_valid),
    .head_kind   (q_head_kind),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_mark     (is_mark),
    .duration_us (duration_us),
    .last_symbol (last_symbol)
  );

endmodule

FILE: tb/ac_ir_frame_encoder_top_tb.sv
`timescale 1ns / 1ps
module ac_ir_frame_encoder_top_tb;
  import acir_pkg::*;

  // Command codes on the action field.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // Register indexes past the last timing register; writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int FRAME_SYMS   = FINAL_SYM + 1;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 260;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE_TICKS = 6;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic       act;
    logic [7:0] temp;
    logic [3:0] mode;
    logic       pwr;
    logic [3:0] fan;
    logic [3:0] swing;
    logic [7:0] eco;
  } ir_cmd_t;

  typedef struct packed {
    logic             is_mark;
    logic [DUR_W-1:0] dur;
    logic             last;
  } ir_sym_t;

  typedef struct packed {
    ir_cmd_t cmd;
    logic    typed;
    ir_sym_t sym;
  } script_row_t;

  // Symbols as they come out under the reset timing values.
  localparam ir_sym_t EXP_MARK   = '{1'b1, MARK_US_RST, 1'b0};
  localparam ir_sym_t EXP_ZERO   = '{1'b0, ZERO_SPACE_US_RST, 1'b0};
  localparam ir_sym_t EXP_ONE    = '{1'b0, ONE_SPACE_US_RST, 1'b0};
  localparam ir_sym_t EXP_LEAD   = '{1'b0, LEAD_GAP_US_RST, 1'b0};
  localparam ir_sym_t EXP_HMARK  = '{1'b1, HEADER_MARK_US_RST, 1'b0};
  localparam ir_sym_t EXP_HSPACE = '{1'b0, HEADER_SPACE_US_RST, 1'b0};
  localparam ir_sym_t EXP_NONE   = '0;

  localparam ir_cmd_t FETCH_ONES  = '{ACT_FETCH, 8'hFF, 4'hF, 1'b1, 4'hF, 4'hF, 8'hFF};
  localparam ir_cmd_t FETCH_ZEROS = '{ACT_FETCH, 8'h00, 4'h0, 1'b0, 4'h0, 4'h0, 8'h00};
  localparam ir_cmd_t LOAD_ZEROS  = '{ACT_LOAD, 8'h00, 4'h0, 1'b0, 4'h0, 4'h0, 8'h00};
  localparam ir_cmd_t LOAD_ONES   = '{ACT_LOAD, 8'hFF, 4'hF, 1'b1, 4'hF, 4'hF, 8'hFF};

  // Directed script: fetch with nothing loaded, an all-zero frame walked through the
  // preamble, lead gap, header and first data bit, then an all-ones load that restarts
  // the frame mid-way.
  localparam script_row_t DIRECTED [21] = '{
    '{FETCH_ONES,  1'b0, EXP_NONE},
    '{LOAD_ZEROS,  1'b0, EXP_NONE},
    '{FETCH_ONES,  1'b1, EXP_MARK},
    '{FETCH_ZEROS, 1'b1, EXP_ZERO},
    '{FETCH_ONES,  1'b1, EXP_MARK},
    '{FETCH_ZEROS, 1'b1, EXP_ZERO},
    '{FETCH_ONES,  1'b1, EXP_MARK},
    '{FETCH_ZEROS, 1'b1, EXP_ZERO},
    '{FETCH_ONES,  1'b1, EXP_MARK},
    '{FETCH_ZEROS, 1'b1, EXP_ZERO},
    '{FETCH_ONES,  1'b1, EXP_MARK},
    '{FETCH_ZEROS, 1'b1, EXP_ZERO},
    '{FETCH_ONES,  1'b1, EXP_MARK},
    '{FETCH_ZEROS, 1'b1, EXP_LEAD},
    '{FETCH_ONES,  1'b1, EXP_HMARK},
    '{FETCH_ZEROS, 1'b1, EXP_HSPACE},
    '{FETCH_ONES,  1'b1, EXP_MARK},
    '{FETCH_ZEROS, 1'b1, EXP_ONE},
    '{LOAD_ONES,   1'b0, EXP_NONE},
    '{FETCH_ZEROS, 1'b1, EXP_MARK},
    '{FETCH_ONES,  1'b0, EXP_NONE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic                   action    = ACT_LOAD;
  logic [7:0]             temp_code = '0;
  logic [3:0]             mode      = '0;
  logic                   power_off = 1'b0;
  logic [3:0]             fan       = '0;
  logic [3:0]             swing     = '0;
  logic [7:0]             eco       = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   is_mark;
  logic [DUR_W-1:0]       duration_us;
  logic                   last_symbol;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Typed expectation riding along with the payload of a directed row.
  logic    row_typed = 1'b0;
  ir_sym_t row_sym   = '0;

  // Frame state and timing registers as the encoder should hold them.
  logic [7:0]             f_temp, f_mode_pwr, f_fan_swing, f_eco, f_sum;
  logic [SYM_INDEX_W-1:0] f_idx;
  logic                   f_live;
  logic [DUR_W-1:0]       timing [6];

  ir_sym_t symbols_owed [$];

  int unsigned errors         = 0;
  int unsigned symbols_seen   = 0;
  int unsigned frames_done    = 0;
  int unsigned commands_taken = 0;
  int          hold_req       = 0;

  // Sender burst bookkeeping; offering mirrors in_valid so it is never assigned twice.
  int unsigned burst_left = 0;
  int unsigned gap;
  bit          offering   = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ac_ir_frame_encoder_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .temp_code   (temp_code),
    .mode        (mode),
    .power_off   (power_off),
    .fan         (fan),
    .swing       (swing),
    .eco         (eco),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_mark     (is_mark),
    .duration_us (duration_us),
    .last_symbol (last_symbol),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Byte n of the frame as it stands now.
  function automatic logic [7:0] octet_of(input int n);
    case (n)
      0:       return BYTE_0;
      1:       return BYTE_1;
      2:       return BYTE_2;
      5:       return f_mode_pwr;
      6:       return f_temp;
      8:       return f_fan_swing;
      15:      return BYTE_15;
      16:      return f_eco;
      18:      return f_sum;
      default: return 8'h00;
    endcase
  endfunction

  // Apply one accepted command to the frame state and give the symbol it yields, if any.
  task automatic step_frame(input ir_cmd_t c, output logic made, output ir_sym_t s);
    logic [SYM_INDEX_W-1:0] k;
    logic [7:0]             octet;
    logic [7:0]             acc;
    made = 1'b0;
    s    = '0;
    if (c.act == ACT_LOAD) begin
      f_temp      = c.temp;
      f_mode_pwr  = {c.mode, 3'b000, c.pwr};
      f_fan_swing = {c.fan, c.swing};
      f_eco       = c.eco;
      acc = 8'h00;
      for (int n = 0; n < 18; n++) acc += octet_of(n);
      f_sum  = acc;
      f_idx  = '0;
      f_live = 1'b1;
    end else if (f_live) begin
      made = 1'b1;
      if (f_idx < PREAMBLE_SYMS) begin
        s.is_mark = ~f_idx[0];
        if (s.is_mark)
          s.dur = timing[CFG_MARK_US];
        else if (f_idx == PREAMBLE_SYMS - 1)
          s.dur = timing[CFG_LEAD_GAP_US];
        else
          s.dur = timing[CFG_ZERO_SPACE_US];
      end else if (f_idx == HDR_MARK_SYM) begin
        s.is_mark = 1'b1;
        s.dur     = timing[CFG_HEADER_MARK_US];
      end else if (f_idx == HDR_SPACE_SYM) begin
        s.is_mark = 1'b0;
        s.dur     = timing[CFG_HEADER_SPACE_US];
      end else if (f_idx < FINAL_SYM) begin
        // Two symbols per bit: k[3:1] picks the bit, k >> 4 the byte.
        k         = f_idx - SYM_INDEX_W'(DATA_START);
        octet     = octet_of(int'(k[8:4]));
        s.is_mark = ~k[0];
        if (s.is_mark)
          s.dur = timing[CFG_MARK_US];
        else
          s.dur = octet[k[3:1]] ? timing[CFG_ONE_SPACE_US] : timing[CFG_ZERO_SPACE_US];
      end else begin
        s.is_mark = 1'b1;
        s.dur     = timing[CFG_MARK_US];
        s.last    = 1'b1;
      end
      if (s.last) begin
        f_live = 1'b0;
        f_idx  = '0;
      end else begin
        f_idx = f_idx + 1'b1;
      end
    end
  endtask

  task automatic flag_symbol(input string what, input ir_sym_t want, input ir_sym_t got);
    errors++;
    if (errors <= 10)
      $display("%s: expected mark=%0b dur=%0d last=%0b, got mark=%0b dur=%0d last=%0b",
               what, want.is_mark, want.dur, want.last, got.is_mark, got.dur, got.last);
  endtask

  // Scoreboard: track register writes, predict on every command transfer, and check
  // every symbol transfer against the oldest owed symbol. All reads see pre-edge values.
  always @(posedge clk) begin : scoreboard
    ir_cmd_t cmd;
    ir_sym_t made_sym, want, got;
    logic    made;
    if (rst) begin
      timing[CFG_MARK_US]         = MARK_US_RST;
      timing[CFG_ZERO_SPACE_US]   = ZERO_SPACE_US_RST;
      timing[CFG_ONE_SPACE_US]    = ONE_SPACE_US_RST;
      timing[CFG_LEAD_GAP_US]     = LEAD_GAP_US_RST;
      timing[CFG_HEADER_MARK_US]  = HEADER_MARK_US_RST;
      timing[CFG_HEADER_SPACE_US] = HEADER_SPACE_US_RST;
      f_temp      = '0;
      f_mode_pwr  = '0;
      f_fan_swing = '0;
      f_eco       = '0;
      f_sum       = '0;
      f_idx       = '0;
      f_live      = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= CFG_HEADER_SPACE_US)
        timing[cfg_index] = cfg_data;
      if (in_valid && !in_stall) begin
        cmd = '{action, temp_code, mode, power_off, fan, swing, eco};
        step_frame(cmd, made, made_sym);
        commands_taken++;
        // A typed row overrides the prediction; the prediction still advances the state.
        if (row_typed)
          symbols_owed.push_back(row_sym);
        else if (made)
          symbols_owed.push_back(made_sym);
      end
      if (out_valid && !out_stall) begin
        got = '{is_mark, duration_us, last_symbol};
        symbols_seen++;
        if (symbols_owed.size() == 0) begin
          flag_symbol("unexpected symbol", EXP_NONE, got);
        end else begin
          want = symbols_owed.pop_front();
          if (got.is_mark !== want.is_mark || got.dur !== want.dur || got.last !== want.last)
            flag_symbol("symbol mismatch", want, got);
          else if (got.last)
            frames_done++;
        end
      end
    end
  end

  // Symbol sink: switch between stall patterns every so often, and serve long
  // hold-offs on request so the encoder backs up into its input.
  initial begin : symbol_sink
    int served, hold_left, pace, pace_left, tick;
    served    = 0;
    hold_left = 0;
    pace      = 0;
    pace_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req != served) begin
        served    = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pace_left == 0) begin
          pace      = $urandom_range(0, 3);
          pace_left = $urandom_range(20, 200);
        end
        pace_left--;
        case (pace)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("timeout after %0d cycles, %0d symbols still owed", cyc, symbols_owed.size());
    $display("TB_ERROR");
    $finish;
  end

  function automatic ir_cmd_t rand_cmd(input logic act);
    ir_cmd_t c;
    c.act   = act;
    c.temp  = 8'($urandom_range(0, 255));
    c.mode  = 4'($urandom_range(0, 15));
    c.pwr   = 1'($urandom_range(0, 1));
    c.fan   = 4'($urandom_range(0, 15));
    c.swing = 4'($urandom_range(0, 15));
    c.eco   = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Offer one command and hold it until transferred; then advance the burst and, when
  // the burst runs out, pick a new one and maybe drop valid for a random gap.
  task automatic offer(input ir_cmd_t c, input logic typed, input ir_sym_t s);
    in_valid <= 1'b1;
    offering  = 1'b1;
    {action, temp_code, mode, power_off, fan, swing, eco} <= c;
    row_typed <= typed;
    row_sym   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = (gap == 0) ? $urandom_range(20, 80) : $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        offering  = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait for every owed symbol, then wait out SETTLE_TICKS so a
  // trailing fetch that yields nothing has drained too.
  task automatic settle();
    if (offering) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
    end
    while (symbols_owed.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [DUR_W-1:0] vals [6];
    int  p, pick, n, phase_items, total_items;
    bit  held;
    held        = 1'b0;
    total_items = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Writes past the last register must leave the reset timing alone,
    // which the typed rows below then confirm.
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h0000);
    cfg_valid <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) offer(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].sym);
    settle();

    for (p = 0; p < PHASES; p++) begin
      // Phase 0 runs on the reset timing; the others reprogram every register.
      if (p != 0) begin
        for (int r = 0; r < 6; r++) begin
          case (p)
            1:       vals[r] = 16'h0000;
            2:       vals[r] = 16'hFFFF;
            default: vals[r] = ($urandom_range(0, 7) == 0) ? 16'hFFFF :
                               DUR_W'($urandom_range(1, 65535));
          endcase
        end
        if (p == 4) begin
          vals[CFG_MARK_US]         = 16'd1;
          vals[CFG_ZERO_SPACE_US]   = 16'd0;
          vals[CFG_ONE_SPACE_US]    = 16'hFFFF;
          vals[CFG_LEAD_GAP_US]     = 16'hFFFF;
          vals[CFG_HEADER_MARK_US]  = 16'd0;
          vals[CFG_HEADER_SPACE_US] = 16'h8000;
        end
        for (int r = 0; r < 6; r++) write_reg(CFG_INDEX_W'(r), vals[r]);
        if ($urandom_range(0, 1) == 1)
          write_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                    DUR_W'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
        @(posedge clk);
      end

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // Open each phase with a whole frame; mostly frames afterwards, some noise.
        pick = (phase_items == 0) ? 0 : $urandom_range(0, 9);
        if (pick <= 6) begin
          offer(rand_cmd(ACT_LOAD), 1'b0, EXP_NONE);
          if (p == 3 && !held) begin
            // Hold the sink off while fetches keep coming so the encoder fills up.
            hold_req <= hold_req + 1;
            held = 1'b1;
          end
          if (pick <= 3) begin
            // Whole frame, plus a few fetches after its end that must yield nothing.
            n = FRAME_SYMS + $urandom_range(0, 3);
            phase_items += 1 + n;
          end else begin
            // Cut short: the next load restarts the frame.
            n = $urandom_range(1, FRAME_SYMS - 1);
            phase_items += 1 + n;
          end
          repeat (n) offer(rand_cmd(ACT_FETCH), 1'b0, EXP_NONE);
        end else begin
          n = $urandom_range(1, 12);
          repeat (n) offer(rand_cmd(1'($urandom_range(0, 1))), 1'b0, EXP_NONE);
          phase_items += n;
        end
      end
      total_items += phase_items;
      settle();
    end

    settle();
    if (symbols_owed.size() != 0) begin
      $display("%0d symbols never arrived", symbols_owed.size());
      errors++;
    end
    $display("Run took %0d commands (%0d random) over %0d timing settings and a directed walk,",
             commands_taken, total_items, PHASES);
    $display("checking %0d symbols including %0d complete frames; %0d mismatches.",
             symbols_seen, frames_done, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/acir_pkg.sv
hw/rtl/acir_front.sv
hw/rtl/acir_queue.sv
hw/rtl/acir_back.sv
hw/rtl/ac_ir_frame_encoder_top.sv
tb/ac_ir_frame_encoder_top_tb.sv
